[hw/rtl/rtp_dfr_pkg.sv]
`default_nettype none

package rtp_dfr_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned SsrcW     = 32;
    localparam int unsigned LenW      = 16;
    localparam int unsigned WinLen    = 15;
    localparam int unsigned WinIdxW   = 4;
    localparam int unsigned UdpHdr    = 12;
    localparam int unsigned UdpSsrcAt = 8;
    localparam int unsigned TcpSsrcAt = 10;
    localparam int unsigned MinRtpLen = 12;
    localparam int unsigned MaxInWin  = 13;
    localparam int unsigned CfgIdxW   = 2;

    localparam int unsigned QDepth    = 4;
    localparam int unsigned QPtrW     = $clog2(QDepth);
    localparam int unsigned QCntW     = $clog2(QDepth + 1);

    localparam logic ModeUdp = 1'b0;
    localparam logic ModeTcp = 1'b1;

    localparam logic [ByteW-1:0] RtpV2      = 8'h80;
    localparam logic [ByteW-1:0] RtpV2Ext   = 8'h90;
    localparam logic [ByteW-1:0] PtDyn96    = 8'h60;
    localparam logic [ByteW-1:0] PtDyn96M   = 8'hE0;
    localparam logic [ByteW-1:0] PtDyn98    = 8'h62;
    localparam logic [ByteW-1:0] PtDyn98M   = 8'hE2;
    localparam logic [ByteW-1:0] PtDyn99    = 8'h63;
    localparam logic [ByteW-1:0] PtDyn99M   = 8'hE3;
    localparam logic [ByteW-1:0] PtDyn108   = 8'h6C;
    localparam logic [ByteW-1:0] PtDyn108M  = 8'hEC;
    localparam logic [ByteW-1:0] PtDyn40M   = 8'hA8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TRANSPORT_MODE = 2'd0,
        CFG_EXPECTED_SSRC  = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [ByteW-1:0] packet_byte;
        logic             packet_last;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;
        logic push;
    } t_front_status;

    function automatic logic marker_ok(input logic [ByteW-1:0] b);
        return b inside {RtpV2, RtpV2Ext};
    endfunction

    function automatic logic payload_ok(input logic [ByteW-1:0] b);
        return b inside {PtDyn96, PtDyn96M, PtDyn98, PtDyn98M, PtDyn99, PtDyn99M,
                         PtDyn108, PtDyn108M, PtDyn40M};
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rtp_dfr_front.sv]
`default_nettype none

module rtp_dfr_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    input  wire logic [rtp_dfr_pkg::ByteW-1:0]         i_s_data,
    input  wire logic                                  i_s_end,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rtp_dfr_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [rtp_dfr_pkg::SsrcW-1:0]         i_cfg_data,
    input  wire rtp_dfr_pkg::t_q_status                i_q_status,
    output rtp_dfr_pkg::t_q_entry                      o_q_entry,
    output rtp_dfr_pkg::t_front_status                 o_status
);

    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } t_state;

    localparam int unsigned BW = rtp_dfr_pkg::ByteW;
    localparam int unsigned IW = rtp_dfr_pkg::WinIdxW;
    localparam int unsigned LW = rtp_dfr_pkg::LenW;
    localparam int unsigned SW = rtp_dfr_pkg::SsrcW;

    t_state              r_state, n_state;
    logic                r_mode, n_mode;
    logic [SW-1:0]       r_expected, n_expected;
    logic [SW-1:0]       r_learned, n_learned;
    logic                r_known, n_known;
    logic [IW-1:0]       r_fill, n_fill;
    logic [LW-1:0]       r_left, n_left;
    logic [IW-1:0]       r_dindex, n_dindex;
    logic                r_passing, n_passing;
    logic [IW-1:0]       r_ptr, n_ptr;
    logic [IW-1:0]       r_end, n_end;
    logic                r_end_last, n_end_last;
    logic [BW-1:0]       r_window [rtp_dfr_pkg::WinLen];
    logic [BW-1:0]       n_window [rtp_dfr_pkg::WinLen];

    logic                accept;
    logic                push;
    logic [LW-1:0]       tcp_len;
    logic                tcp_hdr_ok;
    logic [SW-1:0]       tcp_ssrc;
    logic [SW-1:0]       udp_ssrc;
    logic [SW-1:0]       cand_ssrc;
    logic                judge;
    logic                ssrc_match;
    logic                tcp_check;
    logic                udp_judge;

    assign o_s_tready  = (r_state == ST_RUN) && !i_q_status.full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;

    assign tcp_len    = {r_window[0], r_window[1]};
    assign tcp_hdr_ok = rtp_dfr_pkg::marker_ok(r_window[2]) &&
                        rtp_dfr_pkg::payload_ok(r_window[3]);
    assign tcp_ssrc   = {r_window[rtp_dfr_pkg::TcpSsrcAt],
                         r_window[rtp_dfr_pkg::TcpSsrcAt + 1],
                         r_window[rtp_dfr_pkg::TcpSsrcAt + 2],
                         r_window[rtp_dfr_pkg::TcpSsrcAt + 3]};

    // Header bytes not yet stored come from the incoming byte or read as zero.
    always_comb begin
        udp_ssrc = '0;
        for (int k = 0; k < 4; k++) begin
            if (IW'(rtp_dfr_pkg::UdpSsrcAt + k) < r_dindex) begin
                udp_ssrc[SW-1-8*k -: 8] = r_window[rtp_dfr_pkg::UdpSsrcAt + k];
            end else if (IW'(rtp_dfr_pkg::UdpSsrcAt + k) == r_dindex) begin
                udp_ssrc[SW-1-8*k -: 8] = i_s_data;
            end
        end
    end

    assign tcp_check = accept && (r_mode == rtp_dfr_pkg::ModeTcp) && (r_left == '0) &&
                       (r_fill == IW'(rtp_dfr_pkg::WinLen - 1));
    assign udp_judge = accept && (r_mode == rtp_dfr_pkg::ModeUdp) &&
                       (r_dindex != IW'(rtp_dfr_pkg::UdpHdr)) &&
                       ((r_dindex == IW'(rtp_dfr_pkg::UdpHdr - 1)) || i_s_end);
    assign cand_ssrc = (r_mode == rtp_dfr_pkg::ModeTcp) ? tcp_ssrc : udp_ssrc;
    assign judge     = (tcp_check && tcp_hdr_ok) || udp_judge;

    always_comb begin
        if (r_expected != '0) begin
            ssrc_match = (cand_ssrc == r_expected);
        end else begin
            ssrc_match = !r_known || (cand_ssrc == r_learned);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_expected = r_expected;
        n_learned  = r_learned;
        n_known    = r_known;
        n_fill     = r_fill;
        n_left     = r_left;
        n_dindex   = r_dindex;
        n_passing  = r_passing;
        n_ptr      = r_ptr;
        n_end      = r_end;
        n_end_last = r_end_last;
        n_window   = r_window;
        push       = 1'b0;
        o_q_entry  = '{packet_byte: r_window[r_ptr],
                       packet_last: r_end_last && (r_ptr == r_end)};

        if (judge && (r_expected == '0) && !r_known) begin
            n_learned = cand_ssrc;
            n_known   = 1'b1;
        end

        // Replay buffered header bytes one per cycle while the queue has room.
        if ((r_state == ST_EMIT) && !i_q_status.full) begin
            push = 1'b1;
            if (r_ptr == r_end) begin
                n_state = ST_RUN;
            end else begin
                n_ptr = r_ptr + IW'(1);
            end
        end

        if (accept) begin
            if (r_mode == rtp_dfr_pkg::ModeTcp) begin
                if (r_left != '0) begin
                    push      = 1'b1;
                    o_q_entry = '{packet_byte: i_s_data, packet_last: r_left == LW'(1)};
                    n_left    = r_left - LW'(1);
                end else if (!tcp_check) begin
                    n_window[r_fill] = i_s_data;
                    n_fill           = r_fill + IW'(1);
                end else if (tcp_hdr_ok && ssrc_match &&
                             (tcp_len >= LW'(rtp_dfr_pkg::MinRtpLen))) begin
                    n_window[rtp_dfr_pkg::WinLen-1] = i_s_data;
                    n_state = ST_EMIT;
                    n_ptr   = IW'(2);
                    if (tcp_len > LW'(rtp_dfr_pkg::MaxInWin)) begin
                        n_end      = IW'(rtp_dfr_pkg::WinLen - 1);
                        n_end_last = 1'b0;
                        n_fill     = '0;
                        n_left     = tcp_len - LW'(rtp_dfr_pkg::MaxInWin);
                    end else if (tcp_len == LW'(rtp_dfr_pkg::MaxInWin)) begin
                        n_end      = IW'(rtp_dfr_pkg::WinLen - 1);
                        n_end_last = 1'b1;
                        n_fill     = '0;
                    end else begin
                        // Packet of 12 bytes: the final window byte opens the next frame.
                        n_end       = IW'(rtp_dfr_pkg::WinLen - 2);
                        n_end_last  = 1'b1;
                        n_fill      = IW'(1);
                        n_window[0] = i_s_data;
                    end
                end else begin
                    // Slide the window by one byte.
                    for (int i = 0; i < rtp_dfr_pkg::WinLen - 2; i++) begin
                        n_window[i] = r_window[i+1];
                    end
                    n_window[rtp_dfr_pkg::WinLen-2] = i_s_data;
                end
            end else begin
                if (r_dindex != IW'(rtp_dfr_pkg::UdpHdr)) begin
                    n_window[r_dindex] = i_s_data;
                    n_dindex           = r_dindex + IW'(1);
                    if (udp_judge) begin
                        n_passing = ssrc_match;
                        if (ssrc_match) begin
                            n_state    = ST_EMIT;
                            n_ptr      = '0;
                            n_end      = r_dindex;
                            n_end_last = i_s_end;
                        end
                    end
                end else if (r_passing) begin
                    push      = 1'b1;
                    o_q_entry = '{packet_byte: i_s_data, packet_last: i_s_end};
                end
                if (i_s_end) begin
                    n_dindex  = '0;
                    n_passing = 1'b0;
                end
            end
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                rtp_dfr_pkg::CFG_TRANSPORT_MODE: begin
                    if (i_cfg_data[0] != r_mode) begin
                        n_fill    = '0;
                        n_left    = '0;
                        n_dindex  = '0;
                        n_passing = 1'b0;
                    end
                    n_mode = i_cfg_data[0];
                end
                rtp_dfr_pkg::CFG_EXPECTED_SSRC: begin
                    n_expected = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status = '{busy: r_state == ST_EMIT, push: push};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_mode     <= rtp_dfr_pkg::ModeUdp;
            r_expected <= '0;
            r_learned  <= '0;
            r_known    <= 1'b0;
            r_fill     <= '0;
            r_left     <= '0;
            r_dindex   <= '0;
            r_passing  <= 1'b0;
            r_ptr      <= '0;
            r_end      <= '0;
            r_end_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_expected <= n_expected;
            r_learned  <= n_learned;
            r_known    <= n_known;
            r_fill     <= n_fill;
            r_left     <= n_left;
            r_dindex   <= n_dindex;
            r_passing  <= n_passing;
            r_ptr      <= n_ptr;
            r_end      <= n_end;
            r_end_last <= n_end_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

endmodule

`default_nettype wire

[hw/rtl/rtp_dfr_queue.sv]
`default_nettype none

module rtp_dfr_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire rtp_dfr_pkg::t_q_entry  i_entry,
    input  wire logic                   i_pop,
    output rtp_dfr_pkg::t_q_entry       o_entry,
    output rtp_dfr_pkg::t_q_status      o_status
);

    localparam int unsigned PW = rtp_dfr_pkg::QPtrW;
    localparam int unsigned CW = rtp_dfr_pkg::QCntW;

    rtp_dfr_pkg::t_q_entry r_mem [rtp_dfr_pkg::QDepth];
    logic [PW-1:0]         r_wptr, n_wptr;
    logic [PW-1:0]         r_rptr, n_rptr;
    logic [CW-1:0]         r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_status = '{full:  r_count == CW'(rtp_dfr_pkg::QDepth),
                        empty: r_count == '0};
    assign o_entry  = r_mem[r_rptr];
    assign do_push  = i_push && !o_status.full;
    assign do_pop   = i_pop && !o_status.empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rtp_dfr_back.sv]
`default_nettype none

module rtp_dfr_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire rtp_dfr_pkg::t_q_entry            i_entry,
    input  wire rtp_dfr_pkg::t_q_status           i_q_status,
    output logic                                  o_pop,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [rtp_dfr_pkg::ByteW-1:0]         o_m_data,
    output logic                                  o_m_last
);

    logic                  r_valid, n_valid;
    rtp_dfr_pkg::t_q_entry r_entry;

    // Load the output stage whenever it is empty or being drained.
    assign o_pop = (!r_valid || i_m_tready) && !i_q_status.empty;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_data   = r_entry.packet_byte;
    assign o_m_last   = r_entry.packet_last;

endmodule

`default_nettype wire

[hw/rtl/rtp_stream_deframer_ssrc_filter_core.sv]
// Bytes pass through the queue and the output register. While the output is not stalled,
// one byte per cycle passes when cutting through a packet or passing a datagram, and a TCP
// frame hit replays up to 13 window bytes, one per cycle, from the header window register;
// a UDP header hit replays up to 12. Input is held off during that replay. Reset
// (synchronous, active low) clears mode, SSRC state, fill counts and the queue.
`default_nettype none

module rtp_stream_deframer_ssrc_filter_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rtp_dfr_pkg::ByteW-1:0]    s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tlast,  // datagram_end
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [rtp_dfr_pkg::ByteW-1:0]         m_tdata,  // [7:0] packet_byte
    output logic                                  m_tlast,  // packet_last
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rtp_dfr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [rtp_dfr_pkg::SsrcW-1:0]    i_cfg_data
);

    rtp_dfr_pkg::t_q_entry       push_entry;
    rtp_dfr_pkg::t_q_entry       head_entry;
    rtp_dfr_pkg::t_q_status      q_status;
    rtp_dfr_pkg::t_front_status  front_status;
    logic                        q_pop;

    rtp_dfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_data    (s_tdata),
        .i_s_end     (s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_q_entry   (push_entry),
        .o_status    (front_status)
    );

    rtp_dfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_status.push),
        .i_entry  (push_entry),
        .i_pop    (q_pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    rtp_dfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_data   (m_tdata),
        .o_m_last   (m_tlast)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_status.push |-> !q_status.full)
        else $error("front pushed into a full queue");

    a_no_accept_during_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_status.busy |-> !s_tready)
        else $error("input accepted while replaying header bytes");

    a_pop_only_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("output stage popped an empty queue");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

[verif/rtp_stream_deframer_ssrc_filter_core_tb.sv]
`timescale 1ns / 100ps

module rtp_stream_deframer_ssrc_filter_core_tb;

    localparam int unsigned ClkHalf       = 2;
    localparam int unsigned StallLimit    = 1000;
    localparam int unsigned SettleCycles  = 20;
    localparam int unsigned HoldOffCycles = 80;

    // indexes past the register list; the block must ignore them
    localparam logic [rtp_dfr_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [rtp_dfr_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [rtp_dfr_pkg::SsrcW-1:0] SsrcAllOnes = '1;
    localparam logic [rtp_dfr_pkg::SsrcW-1:0] SsrcLearn   = '0;

    // Tracks the forwarded byte stream the block should produce.
    class fwd_byte_board;
        logic                          mode;
        logic [rtp_dfr_pkg::SsrcW-1:0] want_ssrc;
        logic [rtp_dfr_pkg::SsrcW-1:0] learned_ssrc;
        bit                            learned_ok;
        logic [rtp_dfr_pkg::ByteW-1:0] win [rtp_dfr_pkg::WinLen];
        int unsigned                   fill;
        int unsigned                   cut_left;
        int unsigned                   dg_idx;
        bit                            dg_pass;
        rtp_dfr_pkg::t_q_entry         bytes_due [$];
        int                            errors;

        function new();
            mode         = rtp_dfr_pkg::ModeUdp;
            want_ssrc    = '0;
            learned_ssrc = '0;
            learned_ok   = 1'b0;
            fill         = 0;
            cut_left     = 0;
            dg_idx       = 0;
            dg_pass      = 1'b0;
            errors       = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void write_reg(input logic [rtp_dfr_pkg::CfgIdxW-1:0] idx,
                                input logic [rtp_dfr_pkg::SsrcW-1:0] data);
            if (idx == rtp_dfr_pkg::CFG_TRANSPORT_MODE) begin
                if (data[0] != mode) begin
                    fill     = 0;
                    cut_left = 0;
                    dg_idx   = 0;
                    dg_pass  = 1'b0;
                end
                mode = data[0];
            end else if (idx == rtp_dfr_pkg::CFG_EXPECTED_SSRC) begin
                want_ssrc = data;
            end
        endfunction

        // zero expected SSRC: the first one looked at is learned for good
        function bit ssrc_hit(input logic [rtp_dfr_pkg::SsrcW-1:0] ssrc);
            if (want_ssrc != SsrcLearn) return ssrc == want_ssrc;
            if (!learned_ok) begin
                learned_ssrc = ssrc;
                learned_ok   = 1'b1;
            end
            return ssrc == learned_ssrc;
        endfunction

        function bit pt_listed(input logic [rtp_dfr_pkg::ByteW-1:0] b);
            case (b)
                rtp_dfr_pkg::PtDyn96, rtp_dfr_pkg::PtDyn96M, rtp_dfr_pkg::PtDyn98,
                rtp_dfr_pkg::PtDyn98M, rtp_dfr_pkg::PtDyn99, rtp_dfr_pkg::PtDyn99M,
                rtp_dfr_pkg::PtDyn108, rtp_dfr_pkg::PtDyn108M,
                rtp_dfr_pkg::PtDyn40M: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void push(input logic [rtp_dfr_pkg::ByteW-1:0] b, input bit last);
            rtp_dfr_pkg::t_q_entry e;
            e.packet_byte = b;
            e.packet_last = last;
            bytes_due.push_back(e);
        endfunction

        function void tcp_byte(input logic [rtp_dfr_pkg::ByteW-1:0] b);
            int unsigned                   len;
            int unsigned                   n;
            logic [rtp_dfr_pkg::SsrcW-1:0] ssrc;
            bit                            hit;
            if (cut_left != 0) begin
                cut_left--;
                push(b, cut_left == 0);
                return;
            end
            if (fill >= rtp_dfr_pkg::WinLen) fill = rtp_dfr_pkg::WinLen - 1;
            win[fill] = b;
            fill++;
            if (fill < rtp_dfr_pkg::WinLen) return;
            len  = {win[0], win[1]};
            ssrc = {win[rtp_dfr_pkg::TcpSsrcAt], win[rtp_dfr_pkg::TcpSsrcAt+1],
                    win[rtp_dfr_pkg::TcpSsrcAt+2], win[rtp_dfr_pkg::TcpSsrcAt+3]};
            hit  = 1'b0;
            // SSRC is looked at (and may be learned) before the length test
            if ((win[2] == rtp_dfr_pkg::RtpV2 || win[2] == rtp_dfr_pkg::RtpV2Ext) &&
                pt_listed(win[3]))
                hit = ssrc_hit(ssrc) && (len >= rtp_dfr_pkg::MinRtpLen);
            if (hit) begin
                n = (len < rtp_dfr_pkg::MaxInWin) ? len : rtp_dfr_pkg::MaxInWin;
                for (int unsigned i = 0; i < n; i++)
                    push(win[2+i], (len <= rtp_dfr_pkg::MaxInWin) && (i + 1 == n));
                if (len <= rtp_dfr_pkg::MaxInWin) begin
                    // keep the bytes after a short packet as the next frame start
                    fill = rtp_dfr_pkg::MaxInWin - len;
                    for (int unsigned i = 0; i < fill; i++) win[i] = win[2+len+i];
                end else begin
                    fill     = 0;
                    cut_left = len - rtp_dfr_pkg::MaxInWin;
                end
            end else begin
                for (int unsigned i = 0; i < rtp_dfr_pkg::WinLen - 1; i++) win[i] = win[i+1];
                fill = rtp_dfr_pkg::WinLen - 1;
            end
        endfunction

        function void udp_byte(input logic [rtp_dfr_pkg::ByteW-1:0] b, input bit eop);
            logic [rtp_dfr_pkg::SsrcW-1:0] ssrc;
            if (dg_idx < rtp_dfr_pkg::UdpHdr) begin
                win[dg_idx] = b;
                dg_idx++;
                if (dg_idx == rtp_dfr_pkg::UdpHdr || eop) begin
                    // bytes missing from a short datagram count as zero
                    ssrc = '0;
                    for (int unsigned i = rtp_dfr_pkg::UdpSsrcAt; i < rtp_dfr_pkg::UdpHdr; i++)
                        ssrc = {ssrc[rtp_dfr_pkg::SsrcW-rtp_dfr_pkg::ByteW-1:0],
                                (i < dg_idx) ? win[i] : 8'h00};
                    dg_pass = ssrc_hit(ssrc);
                    if (dg_pass)
                        for (int unsigned i = 0; i < dg_idx; i++)
                            push(win[i], eop && (i + 1 == dg_idx));
                end
            end else if (dg_pass) begin
                push(b, eop);
            end
            if (eop) begin
                dg_idx  = 0;
                dg_pass = 1'b0;
            end
        endfunction

        function void take_rx_byte(input logic [rtp_dfr_pkg::ByteW-1:0] b, input logic eop);
            if (mode == rtp_dfr_pkg::ModeTcp) tcp_byte(b);
            else udp_byte(b, eop);
        endfunction

        task check_fwd_byte(input logic [rtp_dfr_pkg::ByteW-1:0] b, input logic last);
            rtp_dfr_pkg::t_q_entry e;
            if (bytes_due.size() == 0) begin
                report($sformatf("unexpected byte %02h last %0b", b, last));
            end else begin
                e = bytes_due.pop_front();
                if (b !== e.packet_byte)
                    report($sformatf("byte %02h, want %02h", b, e.packet_byte));
                if (last !== e.packet_last)
                    report($sformatf("last %0b on byte %02h, want %0b", last, b,
                                     e.packet_last));
            end
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [rtp_dfr_pkg::ByteW-1:0]     s_tdata;   // [7:0] data_byte
    logic                              s_tlast;   // datagram_end
    logic                              m_tvalid;
    logic                              m_tready;
    logic [rtp_dfr_pkg::ByteW-1:0]     m_tdata;   // [7:0] packet_byte
    logic                              m_tlast;   // packet_last
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [rtp_dfr_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [rtp_dfr_pkg::SsrcW-1:0]     i_cfg_data;

    fwd_byte_board sb = new();

    bit          src_gaps     = 1'b1;
    bit          sink_gaps    = 1'b1;
    bit          hold_req     = 1'b0;
    int unsigned quiet_cycles = 0;

    rtp_stream_deframer_ssrc_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(ClkHalf) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_tvalid && s_tready) sb.take_rx_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_fwd_byte(m_tdata, m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, StallLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial begin : sink
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [rtp_dfr_pkg::ByteW-1:0] b, input logic eop);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // leaves valid high so back-to-back writes need one assignment per step
    task automatic write_cfg(input logic [rtp_dfr_pkg::CfgIdxW-1:0] idx,
                             input logic [rtp_dfr_pkg::SsrcW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic settle();
        s_tvalid    <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [rtp_dfr_pkg::ByteW-1:0] any_listed_pt();
        case ($urandom_range(0, 8))
            0: return rtp_dfr_pkg::PtDyn96;
            1: return rtp_dfr_pkg::PtDyn96M;
            2: return rtp_dfr_pkg::PtDyn98;
            3: return rtp_dfr_pkg::PtDyn98M;
            4: return rtp_dfr_pkg::PtDyn99;
            5: return rtp_dfr_pkg::PtDyn99M;
            6: return rtp_dfr_pkg::PtDyn108;
            7: return rtp_dfr_pkg::PtDyn108M;
            default: return rtp_dfr_pkg::PtDyn40M;
        endcase
    endfunction

    function automatic logic [rtp_dfr_pkg::ByteW-1:0] any_marker();
        return ($urandom_range(0, 1) != 0) ? rtp_dfr_pkg::RtpV2Ext : rtp_dfr_pkg::RtpV2;
    endfunction

    task automatic send_datagram(input logic [rtp_dfr_pkg::SsrcW-1:0] ssrc,
                                 input int unsigned len, input bit close);
        logic [rtp_dfr_pkg::ByteW-1:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            if (i >= rtp_dfr_pkg::UdpSsrcAt && i < rtp_dfr_pkg::UdpHdr)
                b = ssrc[8*(rtp_dfr_pkg::UdpHdr-1-i) +: 8];
            else b = 8'($urandom);
            send_byte(b, close && (i + 1 == len));
        end
    endtask

    // length prefix plus a full 12-byte RTP header even when the length is short
    task automatic send_frame(input logic [rtp_dfr_pkg::SsrcW-1:0] ssrc,
                              input logic [rtp_dfr_pkg::LenW-1:0] len,
                              input logic [rtp_dfr_pkg::ByteW-1:0] marker,
                              input logic [rtp_dfr_pkg::ByteW-1:0] pt);
        logic [rtp_dfr_pkg::ByteW-1:0] b;
        int unsigned                   total;
        total = ((len < rtp_dfr_pkg::MinRtpLen) ? rtp_dfr_pkg::MinRtpLen : len) + 2;
        for (int unsigned i = 0; i < total; i++) begin
            if (i == 0) b = len[15:8];
            else if (i == 1) b = len[7:0];
            else if (i == 2) b = marker;
            else if (i == 3) b = pt;
            else if (i >= rtp_dfr_pkg::TcpSsrcAt && i < rtp_dfr_pkg::TcpSsrcAt + 4)
                b = ssrc[8*(rtp_dfr_pkg::TcpSsrcAt+3-i) +: 8];
            else b = 8'($urandom);
            send_byte(b, 1'($urandom));
        end
    endtask

    task automatic run_udp(input int unsigned segs, input logic [rtp_dfr_pkg::SsrcW-1:0] good);
        for (int unsigned k = 0; k < segs; k++) begin
            case ($urandom_range(0, 5))
                0: send_datagram($urandom, $urandom_range(1, 11), 1'b1);
                1: send_datagram(good ^ (32'd1 << $urandom_range(0, 31)),
                                 $urandom_range(12, 18), 1'b1);
                2: send_datagram(good, rtp_dfr_pkg::UdpHdr, 1'b1);
                default: send_datagram(good, $urandom_range(13, 20), 1'b1);
            endcase
        end
    endtask

    task automatic run_tcp(input int unsigned segs, input logic [rtp_dfr_pkg::SsrcW-1:0] good);
        int unsigned n;
        for (int unsigned k = 0; k < segs; k++) begin
            case ($urandom_range(0, 7))
                0: begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_byte(8'($urandom), 1'($urandom));
                end
                1: send_frame(good ^ (32'd1 << $urandom_range(0, 31)),
                              rtp_dfr_pkg::LenW'($urandom_range(14, 20)),
                              any_marker(), any_listed_pt());
                2: send_frame(good,
                              rtp_dfr_pkg::LenW'($urandom_range(0, rtp_dfr_pkg::MinRtpLen - 1)),
                              any_marker(), any_listed_pt());
                3: send_frame(good, rtp_dfr_pkg::LenW'($urandom_range(14, 20)),
                              8'($urandom), 8'($urandom));
                4: send_frame(good, rtp_dfr_pkg::LenW'(rtp_dfr_pkg::MinRtpLen),
                              any_marker(), any_listed_pt());
                5: send_frame(good, rtp_dfr_pkg::LenW'(rtp_dfr_pkg::MaxInWin),
                              any_marker(), any_listed_pt());
                default: send_frame(good, rtp_dfr_pkg::LenW'($urandom_range(14, 20)),
                                    any_marker(), any_listed_pt());
            endcase
        end
    endtask

    initial begin : stimulus
        logic [rtp_dfr_pkg::SsrcW-1:0] learn_ssrc;
        logic [rtp_dfr_pkg::SsrcW-1:0] short_ssrc;
        logic [rtp_dfr_pkg::SsrcW-1:0] rnd_a;
        logic [rtp_dfr_pkg::SsrcW-1:0] rnd_b;

        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= rtp_dfr_pkg::CFG_TRANSPORT_MODE;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        learn_ssrc = {8'($urandom_range(1, 255)), 24'($urandom)};
        short_ssrc = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 16'h0000};
        rnd_a      = $urandom | 32'h0000_0100;
        rnd_b      = $urandom | 32'h0001_0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // UDP after reset with learning on: the first datagram fixes the SSRC
        send_datagram(learn_ssrc, 13, 1'b1);
        // one-byte datagram reads its SSRC as zero: drop
        send_datagram(learn_ssrc, 1, 1'b1);
        settle();
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, short_ssrc);
        i_cfg_valid <= 1'b0;
        // datagram ending before its SSRC is complete, zero fill matches
        send_datagram(short_ssrc, 10, 1'b1);
        settle();

        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, SsrcLearn);
        write_cfg(CFG_SPARE_LO, SsrcAllOnes);
        i_cfg_valid <= 1'b0;
        run_udp(2, learn_ssrc);
        // leave a datagram open; the mode change must discard it
        send_datagram(learn_ssrc, $urandom_range(1, 11), 1'b0);
        settle();

        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeTcp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, SsrcAllOnes);
        i_cfg_valid <= 1'b0;
        hold_req = 1'b1;
        send_frame(SsrcAllOnes, rtp_dfr_pkg::LenW'(20), rtp_dfr_pkg::RtpV2,
                   rtp_dfr_pkg::PtDyn96);
        run_tcp(1, SsrcAllOnes);
        settle();

        // same mode again: the partly filled window must survive
        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeTcp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, rnd_a);
        write_cfg(CFG_SPARE_HI, rnd_b);
        i_cfg_valid <= 1'b0;
        run_tcp(1, rnd_a);
        settle();

        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeUdp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, SsrcAllOnes);
        i_cfg_valid <= 1'b0;
        run_udp(1, SsrcAllOnes);
        settle();

        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeTcp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, SsrcLearn);
        i_cfg_valid <= 1'b0;
        send_frame(learn_ssrc, rtp_dfr_pkg::LenW'(rtp_dfr_pkg::MinRtpLen),
                   rtp_dfr_pkg::RtpV2Ext, rtp_dfr_pkg::PtDyn40M);
        send_frame(learn_ssrc, rtp_dfr_pkg::LenW'(rtp_dfr_pkg::MaxInWin),
                   rtp_dfr_pkg::RtpV2, rtp_dfr_pkg::PtDyn108M);
        send_frame(learn_ssrc, rtp_dfr_pkg::LenW'(5), rtp_dfr_pkg::RtpV2,
                   rtp_dfr_pkg::PtDyn98);
        run_tcp(1, learn_ssrc);
        settle();

        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeUdp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, rnd_b);
        i_cfg_valid <= 1'b0;
        run_udp(1, rnd_b);
        settle();

        // closing stretch without gaps on either side
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeTcp));
        i_cfg_valid <= 1'b0;
        run_tcp(1, rnd_b);
        settle();
        write_cfg(rtp_dfr_pkg::CFG_TRANSPORT_MODE, rtp_dfr_pkg::SsrcW'(rtp_dfr_pkg::ModeUdp));
        write_cfg(rtp_dfr_pkg::CFG_EXPECTED_SSRC, rnd_a);
        i_cfg_valid <= 1'b0;
        run_udp(1, rnd_a);
        settle();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
